>>> rtl/ultrasonic_echo_ranger_top_defines.svh
// Assertion macros shared by the checker of the echo ranger.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UER_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define UER_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	// Sizing of the sensor bank and the counters.
	localparam int NUM_SENSORS  = 3;
	localparam int COUNT_BITS   = 20;
	localparam int SENSOR_BITS  = 3;
	localparam int CHAN_BITS    = 2;
	localparam int PULSE_BITS   = 8;
	localparam int TIMEOUT_BITS = 20;
	localparam int WIDTH_BITS   = 20;
	localparam int CFG_BITS     = 20;

	localparam logic [CHAN_BITS-1:0]   CH_MAX      = CHAN_BITS'(NUM_SENSORS);
	localparam logic [SENSOR_BITS-1:0] SENSOR_MASK = SENSOR_BITS'((1 << NUM_SENSORS) - 1);
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX   = '1;

	// Configuration reset values.
	localparam logic [PULSE_BITS-1:0]   PULSE_RST   = PULSE_BITS'(10);
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = TIMEOUT_BITS'(100000);

	// Request kinds.
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_START = 1'b1;

	// Configuration register indexes.
	typedef enum logic {
		REG_TRIGGER_PULSE = 1'b0,
		REG_TIMEOUT       = 1'b1
	} uer_reg_t;

	// Measurement phases.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_WAIT = 2'd2
	} uer_phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_INVALID = 2'd2,
		ST_BUSY    = 2'd3
	} uer_status_t;

	typedef struct packed {
		logic                   req_type;
		logic [CHAN_BITS-1:0]   channel;
		logic [SENSOR_BITS-1:0] echo_levels;
	} uer_in_t;

	typedef struct packed {
		logic [SENSOR_BITS-1:0] trigger_levels;
		logic                   done_res;
		uer_status_t            status;
		logic [WIDTH_BITS-1:0]  echo_width_us;
	} uer_out_t;

	typedef struct packed {
		logic [PULSE_BITS-1:0]   trigger_pulse_us;
		logic [TIMEOUT_BITS-1:0] timeout_us;
	} uer_cfg_t;

endpackage

`default_nettype wire

>>> rtl/uer_cfg.sv
// Configuration register file of the echo ranger: trigger length and timeout.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_cfg
	import uer_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire uer_reg_t            cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data,
	output uer_cfg_t                 cfg
);

	logic [PULSE_BITS-1:0]   pulse_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q   <= PULSE_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIGGER_PULSE: pulse_q   <= cfg_data[PULSE_BITS-1:0];
				REG_TIMEOUT:       timeout_q <= cfg_data[TIMEOUT_BITS-1:0];
			endcase
		end
	end

	assign cfg.trigger_pulse_us = pulse_q;
	assign cfg.timeout_us       = timeout_q;

endmodule

`default_nettype wire

>>> rtl/uer_core.sv
// Measurement state machine and counters of the echo ranger. Computes the
// result of one transaction combinationally and updates its state on accept.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_core
	import uer_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire uer_in_t  req,
	input  wire uer_cfg_t cfg,
	output uer_out_t      res
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	uer_phase_t             phase_q, phase_d;
	logic [CHAN_BITS-1:0]   act_q, act_d;
	logic [COUNT_BITS-1:0]  pc_q, pc_d;
	logic [COUNT_BITS-1:0]  width_q, width_d;
	logic                   seen_q, seen_d;
	logic [SENSOR_BITS-1:0] prev_q, prev_d;

	function automatic logic [SENSOR_BITS-1:0] chan_decode(input logic [CHAN_BITS-1:0] ch);
		logic [SENSOR_BITS-1:0] v;
		v = '0;
		if (ch != '0 && ch <= CH_MAX)
			v = SENSOR_BITS'(1) << (ch - CHAN_BITS'(1));
		return v;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
	endfunction

	logic                   is_start;
	logic                   is_tick;
	logic                   ch_ok;
	logic [SENSOR_BITS-1:0] echo_m;
	logic [SENSOR_BITS-1:0] trig_act;
	logic [CHAN_BITS-1:0]   sel;
	logic                   e_now, e_prev;
	logic                   rise, fall, seen_next;
	logic [COUNT_BITS-1:0]  pc_inc;
	logic [COUNT_BITS-1:0]  width_base, width_step;
	logic [PULSE_BITS-1:0]  pulse_len;
	logic                   trig_end;
	logic                   timed_out;
	logic [WIDTH_BITS-1:0]  width_sat;

	// Request decode and echo edge detection on the active channel.
	assign is_start  = (req.req_type == REQ_START);
	assign is_tick   = (req.req_type == REQ_TICK);
	assign ch_ok     = (req.channel != '0) && (req.channel <= CH_MAX);
	assign echo_m    = req.echo_levels & SENSOR_MASK;
	assign trig_act  = chan_decode(act_q);
	assign sel       = (act_q != '0 && act_q <= CH_MAX) ? act_q - CHAN_BITS'(1) : '0;
	assign e_now     = echo_m[sel];
	assign e_prev    = prev_q[sel];
	assign rise      = e_now & ~e_prev;
	assign fall      = ~e_now & e_prev & seen_q;
	assign seen_next = seen_q | rise;

	// Counter steps and limit compares.
	assign pc_inc     = sat_inc(pc_q);
	assign pulse_len  = (cfg.trigger_pulse_us == '0) ? PULSE_BITS'(1) : cfg.trigger_pulse_us;
	assign trig_end   = (pc_inc >= COUNT_BITS'(pulse_len));
	assign timed_out  = (32'(pc_inc) > 32'(cfg.timeout_us)) || (pc_inc == CNT_MAX);
	assign width_base = rise ? '0 : width_q;
	assign width_step = (e_now && seen_next) ? sat_inc(width_base) : width_base;
	assign width_sat  = (32'(width_q) > 32'(WIDTH_MAX)) ? WIDTH_MAX : WIDTH_BITS'(width_q);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_start && ch_ok)
					phase_d = PH_TRIG;
			end
			PH_TRIG: begin
				if (is_tick && trig_end)
					phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				if (is_tick && (fall || timed_out))
					phase_d = PH_IDLE;
			end
			default: begin
				// An unused phase code returns to idle on the next tick.
				if (is_tick)
					phase_d = PH_IDLE;
			end
		endcase
	end

	// Result fields and counter updates.
	always_comb begin
		res     = '0;
		act_d   = act_q;
		pc_d    = pc_q;
		width_d = width_q;
		seen_d  = seen_q;
		prev_d  = prev_q;
		if (is_start) begin
			if (phase_q != PH_IDLE) begin
				res.done_res       = 1'b1;
				res.status         = ST_BUSY;
				res.trigger_levels = (phase_q == PH_TRIG) ? trig_act : '0;
			end else if (!ch_ok) begin
				res.done_res = 1'b1;
				res.status   = ST_INVALID;
			end else begin
				act_d              = req.channel;
				pc_d               = '0;
				width_d            = '0;
				seen_d             = 1'b0;
				res.trigger_levels = chan_decode(req.channel);
			end
		end else begin
			prev_d = echo_m;
			unique case (phase_q)
				PH_TRIG: begin
					res.trigger_levels = trig_act;
					pc_d               = trig_end ? '0 : pc_inc;
				end
				PH_WAIT: begin
					if (fall) begin
						pc_d              = '0;
						seen_d            = 1'b0;
						res.done_res      = 1'b1;
						res.status        = ST_OK;
						res.echo_width_us = width_sat;
					end else begin
						width_d = width_step;
						if (timed_out) begin
							pc_d         = '0;
							seen_d       = 1'b0;
							res.done_res = 1'b1;
							res.status   = ST_TIMEOUT;
						end else begin
							pc_d   = pc_inc;
							seen_d = seen_next;
						end
					end
				end
				default: begin
					// Idle ticks only track the echo levels.
				end
			endcase
		end
	end

	// State registers, updated once per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			act_q   <= '0;
			pc_q    <= '0;
			width_q <= '0;
			seen_q  <= 1'b0;
			prev_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			act_q   <= act_d;
			pc_q    <= pc_d;
			width_q <= width_d;
			seen_q  <= seen_d;
			prev_q  <= prev_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/uer_out_buf.sv
// Output register with a one-entry skid stage for the echo ranger results.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_out_buf
	import uer_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire uer_out_t push_data,
	output logic          push_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output uer_out_t      out_data
);

	logic     out_valid_q;
	logic     skid_valid_q;
	uer_out_t out_data_q;
	uer_out_t skid_data_q;
	logic     pop;
	logic     load_out;
	logic     load_skid;
	logic     drain_skid;

	// New results may enter as long as the skid entry is free.
	assign push_ready = !skid_valid_q;
	assign pop        = out_valid_q && out_ready;
	assign load_out   = push && (!out_valid_q || pop);
	assign load_skid  = push && out_valid_q && !pop;
	assign drain_skid = !push && pop && skid_valid_q;

	// Occupancy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (load_out || drain_skid)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load_skid)
				skid_valid_q <= 1'b1;
			else if (drain_skid)
				skid_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= push_data;
		else if (drain_skid)
			out_data_q <= skid_data_q;
		if (load_skid)
			skid_data_q <= push_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger for three sensors.
// Depends on uer_pkg, uer_cfg, uer_core and uer_out_buf.
//
// Usage:
// - Input channel (in_valid/in_ready/in_data): each transaction is either a
//   one-microsecond tick carrying the sampled echo levels, or a start request
//   naming a sensor channel. Every input transaction yields exactly one result.
// - Output channel (out_valid/out_ready/out_data): trigger levels, a done flag,
//   a status code and the measured echo width in microseconds.
// - Configuration: cfg_we writes cfg_data into the register chosen by
//   cfg_index in the same cycle; write only while no transaction is in flight.
// - Results: each accepted result is registered in the output or skid stage.
// - Throughput: one transaction per cycle while in_ready is high. The state update for a
//   transaction is a single pass of logic from the state registers to the result register.
// - Stall: the output register plus a one-entry skid stage absorb one stalled
//   result; in_ready drops only while both are full.
// - Reset: arst_n clears the measurement state to idle, empties the output
//   stages and restores trigger length 10 and timeout 100000 ticks.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_top
	import uer_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire uer_in_t             in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output uer_out_t                 out_data,
	input  wire logic                cfg_we,
	input  wire uer_reg_t            cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data
);

	uer_cfg_t cfg;
	uer_out_t res;
	logic     accept;

	assign accept = in_valid && in_ready;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (in_data),
		.cfg    (cfg),
		.res    (res)
	);

	uer_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

>>> rtl/uer_checker.sv
// Port-level checker of the echo ranger, bound to the top level.
// Depends on uer_pkg and ultrasonic_echo_ranger_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_echo_ranger_top_defines.svh"

module uer_checker
	import uer_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire uer_out_t out_data
);

	// A stalled result stays put until it is taken.
	`UER_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

	// With no result pending, the block must take new input.
	`UER_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

	// At most one trigger output is high at a time.
	`UER_ASSERT(a_trig_onehot, out_valid |-> $onehot0(out_data.trigger_levels), "several triggers high")

	// The first edge after reset release shows no result.
	`UER_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> !out_valid, "result present after reset")

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_chk (.*);

`default_nettype wire
